// ===== src/xll_pkg.sv =====
// ----------------------------------------------------------------------------
// XOR linked list package
// Shared widths, command and status codes, and parameter defaults for the
// XOR linked list manager and its channel interfaces.
// ----------------------------------------------------------------------------
package xll_pkg;

  // Default pool size and handle width.
  localparam int NODES_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;

  // Commands carried by a request.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_FIND     = 3'd3,
    CMD_WALK_FWD = 3'd4,
    CMD_WALK_BWD = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

// ===== src/xll_in_if.sv =====
// ----------------------------------------------------------------------------
// XOR linked list request channel
// Valid/ready channel that carries one command request.
// ----------------------------------------------------------------------------
interface xll_in_if #(
  parameter int HANDLE_BITS = xll_pkg::HANDLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [xll_pkg::CMD_W-1:0]         command;
  logic signed [xll_pkg::KEY_W-1:0]  key;
  logic [HANDLE_BITS-1:0]            handle;

  modport source (output valid, command, key, handle, input ready);
  modport sink   (input valid, command, key, handle, output ready);
endinterface

// ===== src/xll_out_if.sv =====
// ----------------------------------------------------------------------------
// XOR linked list result channel
// Valid/ready channel that carries one result of a request.
// ----------------------------------------------------------------------------
interface xll_out_if #(
  parameter int HANDLE_BITS = xll_pkg::HANDLE_BITS_DEF,
  parameter int NODES       = xll_pkg::NODES_DEF
);
  logic                                valid;
  logic                                ready;
  logic [xll_pkg::STATUS_W-1:0]        status;
  logic [HANDLE_BITS-1:0]              found_handle;
  logic signed [xll_pkg::KEY_W-1:0]    found_key;
  logic                                last_result;
  logic [$clog2(NODES+1)-1:0]          entry_count;
  logic                                is_empty;

  modport source (output valid, status, found_handle, found_key, last_result,
                  entry_count, is_empty, input ready);
  modport sink   (input valid, status, found_handle, found_key, last_result,
                  entry_count, is_empty, output ready);
endinterface

// ===== src/xor_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// XOR linked list manager
// Doubly linked list in a fixed node pool, each node holding one XOR link.
// ----------------------------------------------------------------------------
// The block takes one request at a time; in_ch.ready is high only while the
// sequencer is idle, and results leave through a one-entry output register.
// The node stores are read at one address per cycle, so every list walk
// visits one node per cycle while the result register can take a result. A
// rejected insert or a walk of an empty list goes straight to S_EMIT; a find
// or remove compares up to NODES nodes, and a remove then relinks in S_UNL_A
// and S_UNL_B. An insert passes through S_INS_A and S_INS_B.
module xor_linked_list_manager #(
  parameter int NODES       = xll_pkg::NODES_DEF,
  parameter int HANDLE_BITS = xll_pkg::HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  xll_in_if.sink    in_ch,
  xll_out_if.source out_ch
);
  import xll_pkg::*;

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_A, S_INS_B, S_SEARCH, S_UNL_A, S_UNL_B, S_WALK, S_EMIT
  } state_t;

  // Node stores, addressed by slot index minus one.
  logic [KEY_W-1:0]       key_mem    [NODES];
  logic [HANDLE_BITS-1:0] handle_mem [NODES];
  logic [IW-1:0]          link_mem   [NODES];

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [IW-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic [IW-1:0]          len_r, len_nxt;
  logic [NODES-1:0]       in_use_r, in_use_nxt;
  logic [IW-1:0]          prev_r, prev_nxt, cur_r, cur_nxt, next_r, next_nxt;
  logic [IW-1:0]          steps_r, steps_nxt, slot_r, slot_nxt;
  status_t                p_status_r, p_status_nxt;
  logic [HANDLE_BITS-1:0] p_handle_r, p_handle_nxt;
  logic [KEY_W-1:0]       p_key_r, p_key_nxt;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic [KEY_W-1:0]       out_key_r;
  logic                   out_last_r;
  logic [IW-1:0]          out_count_r;

  logic                   accept, slot_free;
  logic [IW-1:0]          rd_idx, rd_link, walk_nxt, free_slot, ins_end;
  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   node_we, link_we;
  logic [IW-1:0]          link_widx, link_wdata;
  logic                   ld;
  status_t                ld_status;
  logic [HANDLE_BITS-1:0] ld_handle;
  logic [KEY_W-1:0]       ld_key;
  logic                   ld_last;

  // Slot index to store address.
  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] idx);
    logic [IW-1:0] t;
    t = idx - IW'(1);
    return t[AW-1:0];
  endfunction

  // Links that point outside the pool read as null.
  function automatic logic [IW-1:0] safe_idx(input logic [IW-1:0] idx);
    return (idx <= IW'(NODES)) ? idx : '0;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) free_slot = IW'(i + 1);
    end
  end

  assign ins_end = (cmd_r == CMD_INS_HEAD) ? head_r : tail_r;

  // The single store read port follows the node the sequencer works on.
  always_comb begin
    unique case (state_r)
      S_INS_B: rd_idx = ins_end;
      S_UNL_A: rd_idx = prev_r;
      S_UNL_B: rd_idx = next_r;
      default: rd_idx = cur_r;
    endcase
  end

  assign rd_link   = link_mem[addr_of(rd_idx)];
  assign rd_key    = key_mem[addr_of(rd_idx)];
  assign rd_handle = handle_mem[addr_of(rd_idx)];
  assign walk_nxt  = safe_idx(prev_r ^ rd_link);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    handle_nxt   = handle_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    len_nxt      = len_r;
    in_use_nxt   = in_use_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    next_nxt     = next_r;
    steps_nxt    = steps_r;
    slot_nxt     = slot_r;
    p_status_nxt = p_status_r;
    p_handle_nxt = p_handle_r;
    p_key_nxt    = p_key_r;
    node_we      = 1'b0;
    link_we      = 1'b0;
    link_widx    = slot_r;
    link_wdata   = ins_end;
    ld           = 1'b0;
    ld_status    = ST_OK;
    ld_handle    = '0;
    ld_key       = '0;
    ld_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = cmd_t'(in_ch.command);
          key_nxt      = in_ch.key;
          handle_nxt   = in_ch.handle;
          prev_nxt     = '0;
          steps_nxt    = '0;
          p_status_nxt = ST_OK;
          p_handle_nxt = '0;
          p_key_nxt    = '0;
          unique case (in_ch.command)
            CMD_INS_HEAD, CMD_INS_TAIL: begin
              if (in_ch.handle == '0) begin
                p_status_nxt = ST_NULL;
                state_nxt    = S_EMIT;
              end else if (&in_use_r) begin
                p_status_nxt = ST_FULL;
                state_nxt    = S_EMIT;
              end else begin
                slot_nxt  = free_slot;
                state_nxt = S_INS_A;
              end
            end
            CMD_REMOVE, CMD_FIND: begin
              cur_nxt   = safe_idx(head_r);
              state_nxt = S_SEARCH;
            end
            CMD_WALK_FWD, CMD_WALK_BWD: begin
              cur_nxt = safe_idx((in_ch.command == CMD_WALK_FWD) ? head_r : tail_r);
              if (cur_nxt == '0) begin
                p_status_nxt = ST_EMPTY;
                state_nxt    = S_EMIT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Fill the new node; its link points at the old end.
      S_INS_A: begin
        node_we    = 1'b1;
        link_we    = 1'b1;
        link_widx  = slot_r;
        link_wdata = ins_end;
        state_nxt  = S_INS_B;
      end

      // Hook the old end to the new node, move the end pointer and claim
      // the slot in the same cycle as the length grows.
      S_INS_B: begin
        if (ins_end != '0) begin
          link_we    = 1'b1;
          link_widx  = ins_end;
          link_wdata = rd_link ^ slot_r;
        end else if (cmd_r == CMD_INS_HEAD) begin
          tail_nxt = slot_r;
        end else begin
          head_nxt = slot_r;
        end
        if (cmd_r == CMD_INS_HEAD) head_nxt = slot_r;
        else                       tail_nxt = slot_r;
        in_use_nxt[addr_of(slot_r)] = 1'b1;
        len_nxt   = len_r + IW'(1);
        state_nxt = S_EMIT;
      end

      // One node compared per cycle, starting at the head.
      S_SEARCH: begin
        if (cur_r == '0 || steps_r == IW'(NODES)) begin
          p_status_nxt = ST_NOT_FOUND;
          state_nxt    = S_EMIT;
        end else if (rd_key == key_r) begin
          p_status_nxt = ST_OK;
          p_handle_nxt = rd_handle;
          p_key_nxt    = key_r;
          next_nxt     = walk_nxt;
          state_nxt    = (cmd_r == CMD_REMOVE) ? S_UNL_A : S_EMIT;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = walk_nxt;
          steps_nxt = steps_r + IW'(1);
        end
      end

      // Relink the predecessor, or move the head.
      S_UNL_A: begin
        if (prev_r != '0) begin
          link_we    = 1'b1;
          link_widx  = prev_r;
          link_wdata = rd_link ^ cur_r ^ next_r;
        end else begin
          head_nxt = next_r;
        end
        state_nxt = S_UNL_B;
      end

      // Relink the successor, or move the tail, and free the slot.
      S_UNL_B: begin
        if (next_r != '0) begin
          link_we    = 1'b1;
          link_widx  = next_r;
          link_wdata = rd_link ^ cur_r ^ prev_r;
        end else begin
          tail_nxt = prev_r;
        end
        in_use_nxt[addr_of(cur_r)] = 1'b0;
        if (len_r != '0) len_nxt = len_r - IW'(1);
        state_nxt = S_EMIT;
      end

      // One result per visited node.
      S_WALK: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_status = ST_OK;
          ld_handle = rd_handle;
          ld_key    = rd_key;
          ld_last   = (walk_nxt == '0) || (steps_r == IW'(NODES - 1));
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            prev_nxt  = cur_r;
            cur_nxt   = walk_nxt;
            steps_nxt = steps_r + IW'(1);
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_status = p_status_r;
          ld_handle = p_handle_r;
          ld_key    = p_key_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Node stores.
  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[addr_of(slot_r)]    <= key_r;
      handle_mem[addr_of(slot_r)] <= handle_r;
    end
    if (link_we) link_mem[addr_of(link_widx)] <= link_wdata;
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      len_r    <= len_nxt;
      in_use_r <= in_use_nxt;
      if (ld)                out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    handle_r   <= handle_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    steps_r    <= steps_nxt;
    slot_r     <= slot_nxt;
    p_status_r <= p_status_nxt;
    p_handle_r <= p_handle_nxt;
    p_key_r    <= p_key_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_handle_r <= ld_handle;
      out_key_r    <= ld_key;
      out_last_r   <= ld_last;
      out_count_r  <= len_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.found_handle = out_handle_r;
  assign out_ch.found_key    = out_key_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.entry_count  = out_count_r;
  assign out_ch.is_empty     = (out_count_r == '0);

`ifndef SYNTHESIS
  // The occupancy map and the length always agree.
  a_len_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == len_r)
    else $error("node map and list length disagree");

  // An empty list has null end pointers.
  a_empty_null_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty list with a non-null end pointer");

  // The length never passes the pool size.
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IW'(NODES))
    else $error("list length beyond the pool size");
`endif

endmodule

// ===== sim/xor_linked_list_manager_tb.sv =====
// ----------------------------------------------------------------------------
// XOR linked list manager testbench
// Drives command requests with random gaps and back-pressure, predicts every
// result with a behavioral list model and compares results field by field.
// ----------------------------------------------------------------------------
module xor_linked_list_manager_tb;
  import xll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = NODES_DEF;
  localparam int HB    = HANDLE_BITS_DEF;
  localparam int CW    = $clog2(NODES + 1);
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HB-1:0]       fhandle;
    logic [KEY_W-1:0]    fkey;
    logic                last;
    logic [CW-1:0]       count;
    logic                empty;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [HB-1:0]    handle;
    bit               typed;    // row carries a typed-in expected result
    result_t          res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;

  xll_in_if  #(.HANDLE_BITS(HB)) in_ch ();
  xll_out_if #(.HANDLE_BITS(HB), .NODES(NODES)) out_ch ();

  xor_linked_list_manager #(.NODES(NODES), .HANDLE_BITS(HB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // List model state.
  logic [KEY_W-1:0] mk [1:NODES];
  logic [HB-1:0]    mh [1:NODES];
  int               ml [1:NODES];
  logic [NODES-1:0] used;
  int               head, tail, len;

  result_t expected_results[$];
  row_t    directed[$];

  function automatic result_t mk_res(int st, logic [HB-1:0] h, logic [KEY_W-1:0] k,
                                     bit last);
    result_t r;
    r.status = STATUS_W'(st); r.fhandle = h; r.fkey = k; r.last = last;
    r.count = CW'(len); r.empty = (len == 0);
    return r;
  endfunction

  // Apply one request to the list model and queue the results it causes.
  task automatic predict_list_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [HB-1:0] h);
    int n, prev, cur, nxt, steps;
    bit hit;
    n = 0; prev = 0; hit = 0;
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (h == 0) begin
          expected_results.push_back(mk_res(ST_NULL, 0, 0, 1));
        end else begin
          for (int i = NODES; i >= 1; i--) if (!used[i-1]) n = i;
          if (n == 0) begin
            expected_results.push_back(mk_res(ST_FULL, 0, 0, 1));
          end else begin
            used[n-1] = 1'b1; mk[n] = key; mh[n] = h;
            if (cmd == CMD_INS_HEAD) begin
              ml[n] = head;
              if (head != 0) ml[head] ^= n; else tail = n;
              head = n;
            end else begin
              ml[n] = tail;
              if (tail != 0) ml[tail] ^= n; else head = n;
              tail = n;
            end
            len++;
            expected_results.push_back(mk_res(ST_OK, 0, 0, 1));
          end
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        cur = head;
        for (steps = 0; cur != 0 && steps < NODES && !hit; steps++) begin
          nxt = prev ^ ml[cur];
          if (nxt > NODES) nxt = 0;
          if (mk[cur] == key) begin
            hit = 1;
            h = mh[cur];
            if (cmd == CMD_REMOVE) begin
              if (prev != 0) ml[prev] ^= (cur ^ nxt); else head = nxt;
              if (nxt != 0) ml[nxt] ^= (cur ^ prev); else tail = prev;
              used[cur-1] = 1'b0;
              if (len > 0) len--;
            end
            expected_results.push_back(mk_res(ST_OK, h, key, 1));
          end else begin
            prev = cur; cur = nxt;
          end
        end
        if (!hit) expected_results.push_back(mk_res(ST_NOT_FOUND, 0, 0, 1));
      end
      CMD_WALK_FWD, CMD_WALK_BWD: begin
        cur = (cmd == CMD_WALK_FWD) ? head : tail;
        if (cur == 0) expected_results.push_back(mk_res(ST_EMPTY, 0, 0, 1));
        while (cur != 0 && n < NODES) begin
          nxt = prev ^ ml[cur];
          if (nxt > NODES) nxt = 0;
          n++;
          expected_results.push_back(mk_res(ST_OK, mh[cur], mk[cur],
                                            nxt == 0 || n == NODES));
          prev = cur; cur = nxt;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, result_t got, result_t exp);
    errors++;
    $display("MISMATCH %s: got %p expected %p", what, got, exp);
  endtask

  // Global cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status; got.fhandle = out_ch.found_handle;
      got.fkey = out_ch.found_key; got.last = out_ch.last_result;
      got.count = out_ch.entry_count; got.empty = out_ch.is_empty;
      if (expected_results.size() == 0) begin
        report("unexpected result", got, got);
      end else begin
        exp = expected_results.pop_front();
        if (got.status !== exp.status) report("status", got, exp);
        else if (got.fhandle !== exp.fhandle) report("found_handle", got, exp);
        else if (got.fkey !== exp.fkey) report("found_key", got, exp);
        else if (got.last !== exp.last) report("last_result", got, exp);
        else if (got.count !== exp.count) report("entry_count", got, exp);
        else if (got.empty !== exp.empty) report("is_empty", got, exp);
      end
    end
  end

  // Send one request after a random gap; predict at acceptance.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [HB-1:0] h, bit typed, result_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.command <= cmd; in_ch.key <= key; in_ch.handle <= h;
    // Ready is sampled at the edge itself, so this is the accepting edge.
    @(posedge clk iff in_ch.ready);
    if (typed) begin
      predict_list_op(cmd, key, h);
      if (expected_results.size() > 0 && cmd <= CMD_FIND) begin
        if (expected_results[$] !== res) begin
          report("typed row", expected_results[$], res);
        end
      end
    end else begin
      predict_list_op(cmd, key, h);
    end
  endtask

  function automatic row_t row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [HB-1:0] h, bit typed = 0, int st = 0,
                               int cnt = 0);
    row_t r;
    r.cmd = cmd; r.key = key; r.handle = h; r.typed = typed;
    r.res = '{status: STATUS_W'(st), fhandle: '0, fkey: '0, last: 1'b1,
              count: CW'(cnt), empty: cnt == 0};
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1)) return KEY_W'($urandom_range(0, 7));
    return $urandom();
  endfunction

  initial begin
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    logic [HB-1:0]    h;
    result_t none;
    used = '0; head = 0; tail = 0; len = 0;
    none = '0;
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.key = '0; in_ch.handle = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty list, null handle, extremes, unknown commands, full pool.
    directed.push_back(row(CMD_WALK_FWD, 0, 1));
    directed.push_back(row(CMD_WALK_BWD, 0, 1));
    directed.push_back(row(CMD_FIND, 5, 0, 1, ST_NOT_FOUND, 0));
    directed.push_back(row(CMD_REMOVE, 5, 0, 1, ST_NOT_FOUND, 0));
    directed.push_back(row(CMD_INS_HEAD, 1, 0, 1, ST_NULL, 0));
    directed.push_back(row(CMD_INS_HEAD, 32'h8000_0000, 16'hFFFF, 1, ST_OK, 1));
    directed.push_back(row(CMD_INS_TAIL, 32'h7FFF_FFFF, 16'h0001, 1, ST_OK, 2));
    directed.push_back(row(CMD_INS_TAIL, 32'hFFFF_FFFF, 16'h5A5A, 1, ST_OK, 3));
    directed.push_back(row(3'd6, 0, 1));
    directed.push_back(row(3'd7, 0, 1));
    directed.push_back(row(CMD_WALK_FWD, 0, 0));
    directed.push_back(row(CMD_WALK_BWD, 0, 0));
    directed.push_back(row(CMD_FIND, 32'h7FFF_FFFF, 0));
    directed.push_back(row(CMD_REMOVE, 32'h7FFF_FFFF, 0));
    directed.push_back(row(CMD_WALK_BWD, 0, 0));
    for (int i = 0; i < 14; i++)
      directed.push_back(row(CMD_INS_HEAD, KEY_W'(i), HB'(16'hA5A0 + i)));
    directed.push_back(row(CMD_INS_TAIL, 9, 16'h1234, 1, ST_FULL, 16));
    directed.push_back(row(CMD_INS_HEAD, 9, 0, 1, ST_NULL, 16));
    directed.push_back(row(CMD_WALK_FWD, 0, 0));
    foreach (directed[i])
      send_request(directed[i].cmd, directed[i].key, directed[i].handle,
                   directed[i].typed, directed[i].res);

    // Long result-side hold-off while requests keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_request(CMD_WALK_BWD, 0, 1, 0, none);

    // Random part: mostly inserts and lookups, half the keys from a small set.
    for (int i = 0; i < 60; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: c = CMD_INS_HEAD;
        3, 4:    c = CMD_INS_TAIL;
        5, 6:    c = CMD_REMOVE;
        7:       c = CMD_FIND;
        8:       c = $urandom_range(0, 1) ? CMD_WALK_FWD : CMD_WALK_BWD;
        default: c = CMD_W'($urandom_range(0, 7));
      endcase
      k = pick_key();
      h = ($urandom_range(0, 15) == 0) ? '0 : HB'($urandom());
      send_request(c, k, h, 0, none);
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/xll_pkg.sv
src/xll_in_if.sv
src/xll_out_if.sv
src/xor_linked_list_manager.sv
sim/xor_linked_list_manager_tb.sv
